### rtl/bdll_pkg.sv
// Package for the bounded doubly linked list core: request kinds, status codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bdll_pkg;
    localparam int DEF_CAPACITY = 64;

    typedef enum logic [2:0] {
        K_INSERT = 3'd0,
        K_PUSH_FRONT = 3'd1,
        K_PUSH_BACK = 3'd2,
        K_POP_FRONT = 3'd3,
        K_FIND = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;
endpackage
`default_nettype wire

### rtl/bounded_doubly_linked_list_core.sv
// Top level of the bounded doubly linked list core: sequencer plus three link/value RAMs.
// Depends on bdll_pkg and bdll_ram.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps an ordered list of up to CAPACITY signed 32-bit values in three
// synchronous RAMs (values, forward links, backward links) with a registered read.
// A request is taken when i_start is high and o_busy is low; exactly one result beat
// follows, shown for one cycle with o_done high, and the receiver cannot hold it off.
// Every memory read has an address state followed by a data state. Insert at a position
// and find walk the chain one node at a time, with one such read for each node. The block
// returns to idle after each result beat, and the next request is taken from there.
// After reset a clearing pass writes the free chain into the forward-link RAM,
// entry by entry, with o_busy high.
module bounded_doubly_linked_list_core
    import bdll_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_kind,
    input  wire logic [6:0]  i_position,
    input  wire logic signed [31:0] i_value,
    output logic             o_done,
    output logic signed [31:0] o_popped_value,
    output logic [5:0]       o_found_position,
    output logic [1:0]       o_status,
    output logic [6:0]       o_element_count
);
    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > 7) ? LW : 7;
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    // States of the sequencer. Each read state issues an address, the next one uses data.
    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_TAKE   = 13'b0000000000100, // read next_link[free_head]
        S_TAKE_D = 13'b0000000001000,
        S_LINK   = 13'b0000000010000, // write links of the new node
        S_WALK   = 13'b0000000100000, // read next or value of the current node
        S_WALK_D = 13'b0000001000000,
        S_PREV   = 13'b0000010000000, // read prev_link[cur] for insert
        S_PREV_D = 13'b0000100000000,
        S_MID    = 13'b0001000000000, // second write of insert in the middle
        S_POP    = 13'b0010000000000, // read value and next of head
        S_POP_D  = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    // Where a new node goes in the chain.
    typedef enum logic [1:0] {
        OP_FRONT = 2'd0,
        OP_BACK  = 2'd1,
        OP_MID   = 2'd2
    } t_op;

    t_state r_state, n_state;
    logic [LW-1:0] r_first, n_first, r_last, n_last, r_free, n_free;
    logic [LW-1:0] r_count, n_count;
    logic [LW-1:0] r_node, n_node, r_cur, n_cur, r_prv, n_prv;
    logic [LW-1:0] r_idx, n_idx;
    logic [2:0]    r_kind, n_kind;
    logic [6:0]    r_pos, n_pos;
    logic [31:0]   r_val, n_val, r_pop, n_pop;
    logic [1:0]    r_st, n_st;
    logic [5:0]    r_found, n_found;
    t_op           r_op, n_op;
    logic          r_mid2, n_mid2;

    // RAM ports
    logic          nx_we, pv_we, vl_we;
    logic [AW-1:0] nx_wa, pv_wa, vl_wa, nx_ra, vl_ra, pv_ra;
    logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
    logic [31:0]   vl_rd;

    bdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd));
    bdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd));
    bdll_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
        .i_clk(i_clk), .i_we(vl_we), .i_waddr(vl_wa), .i_wdata(r_val),
        .i_raddr(vl_ra), .o_rdata(vl_rd));

    always_comb begin
        n_state = r_state; n_first = r_first; n_last = r_last; n_free = r_free;
        n_count = r_count; n_node = r_node; n_cur = r_cur; n_prv = r_prv;
        n_idx = r_idx; n_kind = r_kind; n_pos = r_pos; n_val = r_val;
        n_pop = r_pop; n_st = r_st; n_found = r_found; n_op = r_op; n_mid2 = r_mid2;
        nx_we = 1'b0; pv_we = 1'b0; vl_we = 1'b0;
        nx_wa = r_node[AW-1:0]; pv_wa = r_node[AW-1:0]; vl_wa = r_node[AW-1:0];
        nx_wd = '0; pv_wd = '0;
        nx_ra = r_cur[AW-1:0]; pv_ra = r_cur[AW-1:0]; vl_ra = r_cur[AW-1:0];
        case (r_state)
            S_CLEAR: begin
                // Clearing pass: next_link[i] = i + 1, r_idx walks the RAM.
                nx_we = 1'b1; nx_wa = r_idx[AW-1:0]; nx_wd = r_idx + LW'(1);
                n_idx = r_idx + LW'(1);
                if (r_idx == LW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_kind = i_kind; n_pos = i_position; n_val = i_value;
                    n_pop = '0; n_found = '0; n_st = ST_OK;
                    n_cur = r_first; n_idx = '0;
                    if (i_kind == K_INSERT || i_kind == K_PUSH_FRONT
                        || i_kind == K_PUSH_BACK) begin
                        if (r_count == LW'(CAPACITY)) begin
                            n_st = ST_FULL; n_state = S_DONE;
                        end else begin
                            n_node = r_free; n_state = S_TAKE;
                        end
                    end else if (i_kind == K_POP_FRONT || i_kind == K_FIND) begin
                        if (r_count == '0) begin
                            n_st = ST_EMPTY; n_state = S_DONE;
                        end else begin
                            n_state = (i_kind == K_POP_FRONT) ? S_POP : S_WALK;
                            if (i_kind == K_FIND) n_st = ST_NOT_FOUND;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TAKE: begin
                nx_ra = r_node[AW-1:0];
                vl_we = 1'b1; // store the value into the taken node
                n_state = S_TAKE_D;
            end
            S_TAKE_D: begin
                n_free = nx_rd;
                if (r_kind == K_PUSH_FRONT || (r_kind == K_INSERT && r_pos == '0)
                    || r_count == '0) begin
                    n_op = OP_FRONT; n_state = S_LINK;
                end else if (r_kind == K_PUSH_BACK || CW'(r_pos) >= CW'(r_count)) begin
                    n_op = OP_BACK; n_state = S_LINK;
                end else begin
                    n_op = OP_MID; n_state = S_WALK;
                end
            end
            S_LINK: begin
                if (r_op == OP_FRONT) begin
                    // push front: write node links now, head's prev next cycle.
                    if (!r_mid2) begin
                        nx_we = 1'b1; nx_wd = r_first;
                        pv_we = 1'b1; pv_wd = NIL;
                        n_mid2 = 1'b1;
                    end else begin
                        n_mid2 = 1'b0;
                        if (r_first != NIL) begin
                            pv_we = 1'b1; pv_wa = r_first[AW-1:0]; pv_wd = r_node;
                        end else begin
                            n_last = r_node;
                        end
                        n_first = r_node; n_count = r_count + LW'(1); n_state = S_DONE;
                    end
                end else begin
                    if (!r_mid2) begin
                        nx_we = 1'b1; nx_wd = NIL;
                        pv_we = 1'b1; pv_wd = r_last;
                        n_mid2 = 1'b1;
                    end else begin
                        n_mid2 = 1'b0;
                        if (r_last != NIL) begin
                            nx_we = 1'b1; nx_wa = r_last[AW-1:0]; nx_wd = r_node;
                        end else begin
                            n_first = r_node;
                        end
                        n_last = r_node; n_count = r_count + LW'(1); n_state = S_DONE;
                    end
                end
            end
            S_WALK: begin
                n_state = S_WALK_D;
            end
            S_WALK_D: begin
                if (r_kind == K_FIND) begin
                    if (vl_rd == r_val) begin
                        n_st = ST_OK; n_found = r_idx[5:0]; n_state = S_DONE;
                    end else if (nx_rd == NIL || r_idx == LW'(CAPACITY - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_cur = nx_rd; n_idx = r_idx + LW'(1); n_state = S_WALK;
                    end
                end else if (LW'(r_pos) == r_idx) begin
                    n_state = S_PREV;
                end else begin
                    n_cur = nx_rd; n_idx = r_idx + LW'(1); n_state = S_WALK;
                end
            end
            S_PREV: begin
                n_state = S_PREV_D;
            end
            S_PREV_D: begin
                n_prv = pv_rd;
                // node.prev = prv, node.next = cur
                nx_we = 1'b1; nx_wd = r_cur;
                pv_we = 1'b1; pv_wd = pv_rd;
                n_state = S_MID;
            end
            S_MID: begin
                nx_we = 1'b1; nx_wa = r_prv[AW-1:0]; nx_wd = r_node;
                pv_we = 1'b1; pv_wa = r_cur[AW-1:0]; pv_wd = r_node;
                n_count = r_count + LW'(1); n_state = S_DONE;
            end
            S_POP: begin
                n_state = S_POP_D;
            end
            S_POP_D: begin
                n_pop = vl_rd;
                n_first = nx_rd;
                if (nx_rd != NIL) begin
                    pv_we = 1'b1; pv_wa = nx_rd[AW-1:0]; pv_wd = NIL;
                end else begin
                    n_last = NIL;
                end
                nx_we = 1'b1; nx_wa = r_cur[AW-1:0]; nx_wd = r_free;
                n_free = r_cur; n_count = r_count - LW'(1); n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_first <= NIL; r_last <= NIL; r_free <= '0;
            r_count <= '0; r_idx <= '0; r_mid2 <= 1'b0;
        end else begin
            r_state <= n_state; r_first <= n_first; r_last <= n_last; r_free <= n_free;
            r_count <= n_count; r_idx <= n_idx; r_mid2 <= n_mid2;
        end
        r_node <= n_node; r_cur <= n_cur; r_prv <= n_prv; r_kind <= n_kind;
        r_pos <= n_pos; r_val <= n_val; r_pop <= n_pop; r_st <= n_st;
        r_found <= n_found; r_op <= n_op;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_popped_value = r_pop;
    assign o_found_position = r_found;
    assign o_status = r_st;
    assign o_element_count = 7'(r_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LW'(CAPACITY)) else $error("count over capacity");
    a_empty_links: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count == '0) |-> (r_first == NIL && r_last == NIL))
        else $error("empty list keeps links");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result repeated");
`endif
endmodule
`default_nettype wire

### rtl/bdll_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bdll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
